>>> hw/rtl/dmw_pkg.sv
package dmw_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 128;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int PIX_W      = 8;
  localparam int DISP_W     = 8;
  localparam int CFG_W_W    = 10;
  localparam int CFG_H_W    = 8;
  localparam int CFG_D_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Register reset values
  localparam logic [CFG_W_W-1:0] RST_FRAME_WIDTH  = CFG_W_W'(512);
  localparam logic [CFG_H_W-1:0] RST_FRAME_HEIGHT = CFG_H_W'(128);
  localparam logic [CFG_D_W-1:0] RST_DAMPENING    = CFG_D_W'(1);

  // Derived internal widths
  localparam int EW_W  = $clog2(MAX_WIDTH + 1);
  localparam int EH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int SZ_W  = EW_W + EH_W;

  localparam int DISP_CENTER = 127;
  localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  // Divider width covers the largest displaced coordinate magnitude
  localparam int DV_W  = $clog2(MAX_DIM + DISP_CENTER + 1);
  localparam int SX_W  = DV_W + 1;
  localparam int CNT_W = $clog2(DV_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DV_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_DAMPENING    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_WARP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MSTART,
    ST_MOD,
    ST_FIX,
    ST_ADDR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic warp_start;
    logic step;
    logic mod_start;
    logic fix;
    logic addr_load;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

>>> hw/rtl/dmw_ifs.sv
interface dmw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [dmw_pkg::PIX_W-1:0] pixel_value;
  logic [dmw_pkg::DISP_W-1:0] disp_x_raw;
  logic [dmw_pkg::DISP_W-1:0] disp_y_raw;

  modport source (output valid, operation, pixel_value, disp_x_raw, disp_y_raw,
                  input ready);
  modport sink   (input valid, operation, pixel_value, disp_x_raw, disp_y_raw,
                  output ready);
endinterface

interface dmw_out_if;
  logic                      valid;
  logic                      ready;
  logic [dmw_pkg::PIX_W-1:0] out_pixel;
  logic                      frame_last;

  modport source (output valid, out_pixel, frame_last, input ready);
  modport sink   (input valid, out_pixel, frame_last, output ready);
endinterface

interface dmw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dmw_pkg::CFG_IDX_W-1:0]  index;
  logic [dmw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/dmw_div_lane.sv
module dmw_div_lane (
  input  logic                     clk,
  input  logic                     start,
  input  logic                     step,
  input  logic [dmw_pkg::DV_W-1:0] dividend,
  input  logic [dmw_pkg::DV_W-1:0] divisor,
  output logic [dmw_pkg::DV_W-1:0] quotient,
  output logic [dmw_pkg::DV_W-1:0] remainder
);
  import dmw_pkg::*;

  logic [DV_W-1:0] q_r, q_nxt;
  logic [DV_W-1:0] r_r, r_nxt;
  logic [DV_W-1:0] d_r, d_nxt;
  logic [DV_W:0]   trial;
  logic [DV_W:0]   diff;

  // Restoring division, one quotient bit per step
  always_comb begin
    trial = {r_r, q_r[DV_W-1]};
    diff  = trial - {1'b0, d_r};
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    if (start) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
    end else if (step) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = diff[DV_W-1:0];
        q_nxt = {q_r[DV_W-2:0], 1'b1};
      end else begin
        r_nxt = trial[DV_W-1:0];
        q_nxt = {q_r[DV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign quotient  = q_r;
  assign remainder = r_r;

endmodule

>>> hw/rtl/dmw_datapath.sv
module dmw_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [dmw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [dmw_pkg::PIX_W-1:0]      pixel_value,
  input  logic [dmw_pkg::DISP_W-1:0]     disp_x_raw,
  input  logic [dmw_pkg::DISP_W-1:0]     disp_y_raw,
  input  dmw_pkg::dp_cmd_t               cmd,
  output dmw_pkg::dp_status_t            status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [dmw_pkg::PIX_W-1:0]      out_pixel,
  output logic                           out_last
);
  import dmw_pkg::*;

  // Configuration
  logic [CFG_W_W-1:0] width_r, width_nxt;
  logic [CFG_H_W-1:0] height_r, height_nxt;
  logic [CFG_D_W-1:0] damp_r, damp_nxt;
  logic [EW_W-1:0]    eff_w;
  logic [EH_W-1:0]    eff_h;
  logic [CFG_D_W-1:0] eff_d;
  logic [SZ_W-1:0]    frame_size;

  // Positions
  logic [ADDR_W-1:0] lp_r, lp_nxt, lp_cur;
  logic [SZ_W-1:0]   lp_inc;
  logic [COL_W-1:0]  col_r, col_nxt, col_cl;
  logic [ROW_W-1:0]  row_r, row_nxt, row_cl;
  logic [EW_W-1:0]   col_inc;
  logic [EH_W-1:0]   row_inc;

  // Per-pixel work registers
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic              last_r, last_nxt;
  logic              negx_r, negx_nxt;
  logic              negy_r, negy_nxt;
  logic [COL_W-1:0]  tx_r, tx_nxt;
  logic [ROW_W-1:0]  ty_r, ty_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SZ_W-1:0]   addr_full;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pixel_r, out_pixel_nxt;
  logic              out_last_r, out_last_nxt;

  // Divider lanes
  logic              lane_start;
  logic [DV_W-1:0]   dvd_x, dvd_y, dvs_x, dvs_y;
  logic [DV_W-1:0]   quo_x, quo_y, rem_x, rem_y;
  logic [DISP_W-1:0] mag_x, mag_y;
  logic [SX_W-1:0]   dx, dy, sx, sy;

  // Frame store
  logic [PIX_W-1:0]  store_mem [STORE_DEPTH];
  logic [PIX_W-1:0]  rd_data_r;

  // Out-of-range geometry saturates, zero reads as one
  always_comb begin
    if (width_r == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(width_r);
    end
    if (height_r == '0) begin
      eff_h = EH_W'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      eff_h = EH_W'(MAX_HEIGHT);
    end else begin
      eff_h = EH_W'(height_r);
    end
    eff_d      = (damp_r == '0) ? CFG_D_W'(1) : damp_r;
    frame_size = SZ_W'(eff_w) * SZ_W'(eff_h);
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    damp_nxt   = damp_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width_nxt  = cfg_data[CFG_W_W-1:0];
        CFG_FRAME_HEIGHT: height_nxt = cfg_data[CFG_H_W-1:0];
        CFG_DAMPENING:    damp_nxt   = cfg_data[CFG_D_W-1:0];
        default: ;
      endcase
    end
  end

  // Load position: restart when past the frame, wrap after the last pixel
  always_comb begin
    lp_cur = (SZ_W'(lp_r) >= frame_size) ? '0 : lp_r;
    lp_inc = SZ_W'(lp_cur) + SZ_W'(1);
    lp_nxt = lp_r;
    if (cmd.load) begin
      lp_nxt = (lp_inc >= frame_size) ? '0 : lp_inc[ADDR_W-1:0];
    end
  end

  // Output position, clamped into the current frame
  always_comb begin
    col_cl      = (EW_W'(col_r) >= eff_w) ? '0 : col_r;
    row_cl      = (EH_W'(row_r) >= eff_h) ? '0 : row_r;
    col_inc     = EW_W'(col_cl) + EW_W'(1);
    row_inc     = EH_W'(row_cl) + EH_W'(1);
    col_nxt     = col_r;
    row_nxt     = row_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    last_nxt    = last_r;
    negx_nxt    = negx_r;
    negy_nxt    = negy_r;
    mag_x       = (disp_x_raw >= DISP_W'(DISP_CENTER)) ?
                  disp_x_raw - DISP_W'(DISP_CENTER) : DISP_W'(DISP_CENTER) - disp_x_raw;
    mag_y       = (disp_y_raw >= DISP_W'(DISP_CENTER)) ?
                  disp_y_raw - DISP_W'(DISP_CENTER) : DISP_W'(DISP_CENTER) - disp_y_raw;
    if (cmd.warp_start) begin
      cur_col_nxt = col_cl;
      cur_row_nxt = row_cl;
      last_nxt    = (col_inc == eff_w) && (row_inc == eff_h);
      negx_nxt    = disp_x_raw < DISP_W'(DISP_CENTER);
      negy_nxt    = disp_y_raw < DISP_W'(DISP_CENTER);
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
        row_nxt = row_cl;
      end
    end else if (cmd.mod_start) begin
      // Sign of the displaced coordinate now rides in the flags
      negx_nxt = sx[SX_W-1];
      negy_nxt = sy[SX_W-1];
    end
  end

  // Signed displacement and displaced coordinate, two's complement
  always_comb begin
    dx = negx_r ? (~SX_W'(quo_x) + SX_W'(1)) : SX_W'(quo_x);
    dy = negy_r ? (~SX_W'(quo_y) + SX_W'(1)) : SX_W'(quo_y);
    sx = SX_W'(cur_col_r) + dx;
    sy = SX_W'(cur_row_r) + dy;
  end

  always_comb begin
    lane_start = cmd.warp_start || cmd.mod_start;
    if (cmd.warp_start) begin
      dvd_x = DV_W'(mag_x);
      dvd_y = DV_W'(mag_y);
      dvs_x = DV_W'(eff_d);
      dvs_y = DV_W'(eff_d);
    end else begin
      dvd_x = sx[SX_W-1] ? DV_W'(~sx + SX_W'(1)) : DV_W'(sx);
      dvd_y = sy[SX_W-1] ? DV_W'(~sy + SX_W'(1)) : DV_W'(sy);
      dvs_x = DV_W'(eff_w);
      dvs_y = DV_W'(eff_h);
    end
  end

  dmw_div_lane u_lane_x (
    .clk       (clk),
    .start     (lane_start),
    .step      (cmd.step),
    .dividend  (dvd_x),
    .divisor   (dvs_x),
    .quotient  (quo_x),
    .remainder (rem_x)
  );

  dmw_div_lane u_lane_y (
    .clk       (clk),
    .start     (lane_start),
    .step      (cmd.step),
    .dividend  (dvd_y),
    .divisor   (dvs_y),
    .quotient  (quo_y),
    .remainder (rem_y)
  );

  // Turn a truncated remainder into a true modulo, then form the address
  always_comb begin
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    addr_nxt  = addr_r;
    addr_full = SZ_W'(ty_r) * SZ_W'(eff_w) + SZ_W'(tx_r);
    if (cmd.fix) begin
      tx_nxt = (negx_r && rem_x != '0) ? COL_W'(DV_W'(eff_w) - rem_x) : COL_W'(rem_x);
      ty_nxt = (negy_r && rem_y != '0) ? ROW_W'(DV_W'(eff_h) - rem_y) : ROW_W'(rem_y);
    end
    if (cmd.addr_load) begin
      addr_nxt = addr_full[ADDR_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
      out_pixel_nxt = rd_data_r;
      out_last_nxt  = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store_mem[lp_cur] <= pixel_value;
    end
    rd_data_r <= store_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= RST_FRAME_WIDTH;
      height_r    <= RST_FRAME_HEIGHT;
      damp_r      <= RST_DAMPENING;
      lp_r        <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      damp_r      <= damp_nxt;
      lp_r        <= lp_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_col_r   <= cur_col_nxt;
    cur_row_r   <= cur_row_nxt;
    last_r      <= last_nxt;
    negx_r      <= negx_nxt;
    negy_r      <= negy_nxt;
    tx_r        <= tx_nxt;
    ty_r        <= ty_nxt;
    addr_r      <= addr_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign status.out_busy = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_pixel       = out_pixel_r;
  assign out_last        = out_last_r;

endmodule

>>> hw/rtl/dmw_ctrl.sv
module dmw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_operation,
  output logic                in_ready,
  input  dmw_pkg::dp_status_t status,
  output dmw_pkg::dp_cmd_t    cmd
);
  import dmw_pkg::*;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (op_t'(in_operation) == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.warp_start = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_MSTART;
        end
      end
      ST_MSTART: begin
        cmd.mod_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_MOD;
      end
      ST_MOD: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr_load = 1'b1;
        state_nxt     = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register frees up
        if (!status.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/displacement_map_warp_unit.sv
// Channel   Dir   Payload                                        Handshake
// in_if     in    operation, pixel_value, disp_x_raw, disp_y_raw valid/ready
// out_if    out   out_pixel, frame_last                          valid/ready
// cfg_if    in    index (0 width, 1 height, 2 dampening), data   valid/ready, ready always high
//
// A load request produces nothing; while no warp is in progress one may follow every cycle.
// A warp pixel lands in the output register after two passes of the bit-serial
// divider lanes (dampening divide, then coordinate wrap), address multiply and one
// synchronous frame store read. The next request is taken once that pixel has been
// pushed into the output register.
// rst_n is synchronous; the frame store is not cleared. Input ready is low for the
// whole warp; a pending result holds the final push, and with it the input.
module displacement_map_warp_unit (
  input  logic      clk,
  input  logic      rst_n,
  dmw_in_if.sink    in_if,
  dmw_out_if.source out_if,
  dmw_cfg_if.sink   cfg_if
);
  import dmw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // Sequencer: walks each warp request through the shared datapath steps
  dmw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_operation (in_if.operation),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: registers, frame store, divider lanes and output register
  dmw_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_if.valid),
    .cfg_index   (cfg_if.index),
    .cfg_data    (cfg_if.data),
    .pixel_value (in_if.pixel_value),
    .disp_x_raw  (in_if.disp_x_raw),
    .disp_y_raw  (in_if.disp_y_raw),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_if.ready),
    .out_valid   (out_if.valid),
    .out_pixel   (out_if.out_pixel),
    .out_last    (out_if.frame_last)
  );

  assign in_if.ready  = in_ready;
  // Register writes are never stalled
  assign cfg_if.ready = 1'b1;

endmodule
